[sv/rdm_pkg.sv]
package rdm_pkg;

  localparam int unsigned ECHO_BYTES = 4;
  localparam int unsigned JOBQ_DEPTH = 2;
  localparam int unsigned JOBQ_AW    = $clog2(JOBQ_DEPTH);

  localparam logic [7:0]  SYNC_BYTE     = 8'h05;
  localparam logic [7:0]  CRC_POLY      = 8'h07;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
  localparam logic [3:0]  ECHO_CNT      = 4'(ECHO_BYTES);
  localparam logic [3:0]  REPLY_BODY    = 4'd7;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SYNC    = 3'd1;
  localparam logic [2:0] ST_REG     = 3'd2;
  localparam logic [2:0] ST_CRC     = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // reply byte positions after the echo
  localparam logic [3:0] POS_SYNC = 4'd0;
  localparam logic [3:0] POS_REG  = 4'd2;
  localparam logic [3:0] POS_DATA = 4'd3;

  localparam logic [2:0] IDX_WRITE_LAST = 3'd7;
  localparam logic [2:0] IDX_READ_LAST  = 3'd3;

  typedef enum logic [1:0] {
    JOB_WRITE = 2'd0,
    JOB_READ  = 2'd1,
    JOB_DONE  = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  node_addr;
    logic [6:0]  reg_addr;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        read_done;
    logic [2:0]  status;
    logic [31:0] read_value;
  } rsp_t;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  node_addr;
    logic [6:0]  reg_addr;
    logic [31:0] value;
    logic [2:0]  status;
  } job_t;

  // CRC-8 poly 0x07, data bits taken LSB first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int b = 0; b < 8; b++) begin
      if (c[7] ^ d[0]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

[sv/register_datagram_uart_master.sv]
// Master side of a single-wire UART register datagram link (CRC-8 poly 0x07, LSB-first
// data). A request is accepted in any cycle the two-entry job queue has room; the front
// end tracks the pending read (echo skip, reply check, idle-tick timeout) in the same
// cycle it accepts each byte or tick request. The back end emits one result per cycle
// while its single output register is empty or popped: a write request yields eight
// results, a read request four, a finished read one. Sustained throughput is therefore
// set by the back end's one-result-per-cycle byte sequencer.
module register_datagram_uart_master_core import rdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  req_t        req_i,
  output logic        empty,
  input  logic        pop,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_out;
  logic job_pop;
  logic job_full;
  logic job_empty;

  assign full        = job_full;
  assign accept      = push && !job_full;
  assign cfg_ready_o = 1'b1;

  rdm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  rdm_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  rdm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .rsp_o       (rsp_o)
  );

endmodule

[sv/rdm_front.sv]
module rdm_front import rdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output logic        job_push_o,
  output job_t        job_o
);

  logic        pending_q, pending_d;
  logic [3:0]  bcnt_q, bcnt_d;
  logic [6:0]  preg_q, preg_d;
  logic [7:0]  crc_q, crc_d;
  logic        sync_ok_q, sync_ok_d;
  logic        reg_ok_q, reg_ok_d;
  logic [31:0] data_q, data_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] timeout_q;
  logic [3:0]  pos;
  logic [15:0] idle_inc;
  logic [2:0]  rx_status;

  assign pos      = bcnt_q - ECHO_CNT;
  assign idle_inc = (idle_q < IDLE_MAX) ? idle_q + 16'd1 : idle_q;

  always_comb begin
    if (!sync_ok_q) begin
      rx_status = ST_SYNC;
    end else if (!reg_ok_q) begin
      rx_status = ST_REG;
    end else if (crc_q != req_i.rx_byte) begin
      rx_status = ST_CRC;
    end else begin
      rx_status = ST_OK;
    end
  end

  always_comb begin
    pending_d = pending_q;
    bcnt_d    = bcnt_q;
    preg_d    = preg_q;
    crc_d     = crc_q;
    sync_ok_d = sync_ok_q;
    reg_ok_d  = reg_ok_q;
    data_d    = data_q;
    idle_d    = idle_q;

    job_push_o       = 1'b0;
    job_o.kind       = JOB_DONE;
    job_o.node_addr  = req_i.node_addr;
    job_o.reg_addr   = req_i.reg_addr;
    job_o.value      = req_i.write_value;
    job_o.status     = ST_OK;

    // the read context is cleared by new requests, finished reads and timeouts
    if (accept_i) begin
      case (req_i.cmd)
        CMD_WRITE, CMD_READ: begin
          pending_d  = (req_i.cmd == CMD_READ);
          bcnt_d     = '0;
          preg_d     = (req_i.cmd == CMD_READ) ? req_i.reg_addr : '0;
          crc_d      = '0;
          sync_ok_d  = 1'b0;
          reg_ok_d   = 1'b0;
          data_d     = '0;
          idle_d     = '0;
          job_push_o = 1'b1;
          job_o.kind = (req_i.cmd == CMD_READ) ? JOB_READ : JOB_WRITE;
        end
        CMD_RX: begin
          if (pending_q) begin
            idle_d = '0;
            if (bcnt_q < ECHO_CNT) begin
              bcnt_d = bcnt_q + 4'd1;
            end else if (pos < REPLY_BODY) begin
              if (pos == POS_SYNC) begin
                sync_ok_d = (req_i.rx_byte == SYNC_BYTE);
              end else if (pos == POS_REG) begin
                reg_ok_d = (req_i.rx_byte == {1'b0, preg_q});
              end else if (pos >= POS_DATA) begin
                data_d = {data_q[23:0], req_i.rx_byte};
              end
              crc_d  = crc_byte(crc_q, req_i.rx_byte);
              bcnt_d = bcnt_q + 4'd1;
            end else begin
              job_push_o   = 1'b1;
              job_o.status = rx_status;
              job_o.value  = (rx_status == ST_OK) ? data_q : '0;
              pending_d = 1'b0;
              bcnt_d    = '0;
              preg_d    = '0;
              crc_d     = '0;
              sync_ok_d = 1'b0;
              reg_ok_d  = 1'b0;
              data_d    = '0;
            end
          end
        end
        CMD_TICK: begin
          if (pending_q) begin
            idle_d = idle_inc;
            if (idle_inc >= timeout_q) begin
              job_push_o   = 1'b1;
              job_o.status = ST_TIMEOUT;
              job_o.value  = '0;
              pending_d = 1'b0;
              bcnt_d    = '0;
              preg_d    = '0;
              crc_d     = '0;
              sync_ok_d = 1'b0;
              reg_ok_d  = 1'b0;
              data_d    = '0;
              idle_d    = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      bcnt_q    <= '0;
      preg_q    <= '0;
      crc_q     <= '0;
      sync_ok_q <= 1'b0;
      reg_ok_q  <= 1'b0;
      data_q    <= '0;
      idle_q    <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      pending_q <= pending_d;
      bcnt_q    <= bcnt_d;
      preg_q    <= preg_d;
      crc_q     <= crc_d;
      sync_ok_q <= sync_ok_d;
      reg_ok_q  <= reg_ok_d;
      data_q    <= data_d;
      idle_q    <= idle_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

endmodule

[sv/rdm_jobq.sv]
module rdm_jobq import rdm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t               mem_q [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wptr_q;
  logic [JOBQ_AW-1:0] rptr_q;
  logic [JOBQ_AW:0]   cnt_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == (JOBQ_AW+1)'(JOBQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : wptr_q + JOBQ_AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : rptr_q + JOBQ_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (JOBQ_AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (JOBQ_AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/rdm_back.sv]
module rdm_back import rdm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_empty_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic empty_o,
  input  logic pop_i,
  output rsp_t rsp_o
);

  logic       active_q;
  job_t       job_q;
  logic [2:0] idx_q;
  logic [7:0] crc_q;
  rsp_t       out_q;
  logic       out_vld_q;

  logic       slot_free;
  logic       emit;
  logic       is_last;
  logic       done_emit;
  logic [7:0] byte_val;
  logic       load;
  rsp_t       rsp_new;

  assign slot_free = !out_vld_q || pop_i;
  assign emit      = active_q && slot_free;

  always_comb begin
    case (idx_q)
      3'd0:    byte_val = SYNC_BYTE;
      3'd1:    byte_val = job_q.node_addr;
      3'd2:    byte_val = {(job_q.kind == JOB_WRITE), job_q.reg_addr};
      3'd3:    byte_val = (job_q.kind == JOB_WRITE) ? job_q.value[31:24] : crc_q;
      3'd4:    byte_val = job_q.value[23:16];
      3'd5:    byte_val = job_q.value[15:8];
      3'd6:    byte_val = job_q.value[7:0];
      default: byte_val = crc_q;
    endcase
  end

  assign is_last = (job_q.kind == JOB_WRITE && idx_q == IDX_WRITE_LAST) ||
                   (job_q.kind == JOB_READ && idx_q == IDX_READ_LAST);
  assign done_emit = (job_q.kind == JOB_DONE);

  always_comb begin
    rsp_new = '0;
    if (done_emit) begin
      rsp_new.read_done  = 1'b1;
      rsp_new.status     = job_q.status;
      rsp_new.read_value = job_q.value;
    end else begin
      rsp_new.tx_valid = 1'b1;
      rsp_new.tx_byte  = byte_val;
      rsp_new.last     = is_last;
    end
  end

  // next job is taken when idle or while the current one emits its last result
  assign load      = !job_empty_i && (!active_q || (emit && (is_last || done_emit)));
  assign job_pop_o = load;

  assign empty_o = !out_vld_q;
  assign rsp_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_q <= rsp_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      idx_q     <= '0;
      crc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
      if (load) begin
        active_q <= 1'b1;
        idx_q    <= '0;
        crc_q    <= '0;
      end else if (emit) begin
        if (is_last || done_emit) begin
          active_q <= 1'b0;
        end
        idx_q <= idx_q + 3'd1;
        crc_q <= crc_byte(crc_q, byte_val);
      end
    end
  end

endmodule

[tb/sv/rdm_link_monitor.sv]
`timescale 1ns / 100ps

module rdm_link_monitor import rdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  req_t        req_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  rsp_t        rsp_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          due_cnt_o,
  output int          seen_cnt_o
);

  logic [15:0] tmo_ticks;
  logic        rd_armed;
  logic [3:0]  rx_seen;
  logic [6:0]  want_reg;
  logic [7:0]  reply_crc;
  logic        sync_good;
  logic        reg_good;
  logic [31:0] reply_word;
  logic [15:0] idle_ticks;
  rsp_t        awaited_q[$];
  int          fails;
  int          seen;

  // bit 0 of the data byte enters first (LSB-first)
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    int         i;
    c = crc;
    for (i = 0; i < 8; i++) begin
      c = {c[6:0], 1'b0} ^ ((c[7] ^ data[i]) ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic rsp_t tx_result(input logic [7:0] b, input logic fin);
    rsp_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    r.last     = fin;
    return r;
  endfunction

  function automatic rsp_t done_result(input logic [2:0] st, input logic [31:0] v);
    rsp_t r;
    r = '0;
    r.read_done  = 1'b1;
    r.status     = st;
    r.read_value = v;
    return r;
  endfunction

  function automatic void drop_read();
    rd_armed   = 1'b0;
    rx_seen    = '0;
    want_reg   = '0;
    reply_crc  = '0;
    sync_good  = 1'b0;
    reg_good   = 1'b0;
    reply_word = '0;
    idle_ticks = '0;
  endfunction

  function automatic void predict_link_results(input req_t r);
    logic [7:0] frame [7];
    logic [7:0] crc;
    logic [3:0] pos;
    logic [2:0] st;
    int         n;
    int         i;
    if (r.cmd == CMD_WRITE || r.cmd == CMD_READ) begin
      // any new write or read request silently cancels a pending read
      drop_read();
      frame[0] = SYNC_BYTE;
      frame[1] = r.node_addr;
      frame[2] = {r.cmd == CMD_WRITE, r.reg_addr};
      frame[3] = r.write_value[31:24];
      frame[4] = r.write_value[23:16];
      frame[5] = r.write_value[15:8];
      frame[6] = r.write_value[7:0];
      if (r.cmd == CMD_WRITE) begin
        n = 7;
      end else begin
        n = 3;
        rd_armed = 1'b1;
        want_reg = r.reg_addr;
      end
      crc = '0;
      for (i = 0; i < n; i++) begin
        crc = crc8_step(crc, frame[i]);
        awaited_q.push_back(tx_result(frame[i], 1'b0));
      end
      awaited_q.push_back(tx_result(crc, 1'b1));
    end else if (rd_armed && r.cmd == CMD_RX) begin
      idle_ticks = '0;
      if (rx_seen < ECHO_CNT) begin
        rx_seen++;
      end else begin
        pos = rx_seen - ECHO_CNT;
        if (pos < REPLY_BODY) begin
          if (pos == POS_SYNC) begin
            sync_good = (r.rx_byte == SYNC_BYTE);
          end else if (pos == POS_REG) begin
            reg_good = (r.rx_byte == {1'b0, want_reg});
          end else if (pos >= POS_DATA) begin
            reply_word = {reply_word[23:0], r.rx_byte};
          end
          reply_crc = crc8_step(reply_crc, r.rx_byte);
          rx_seen++;
        end else begin
          if (!sync_good) begin
            st = ST_SYNC;
          end else if (!reg_good) begin
            st = ST_REG;
          end else if (reply_crc != r.rx_byte) begin
            st = ST_CRC;
          end else begin
            st = ST_OK;
          end
          awaited_q.push_back(done_result(st, (st == ST_OK) ? reply_word : 32'd0));
          drop_read();
        end
      end
    end else if (rd_armed && r.cmd == CMD_TICK) begin
      if (idle_ticks != IDLE_MAX) begin
        idle_ticks++;
      end
      if (idle_ticks >= tmo_ticks) begin
        awaited_q.push_back(done_result(ST_TIMEOUT, 32'd0));
        drop_read();
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_result(input rsp_t got);
    rsp_t want;
    seen++;
    if (awaited_q.size() == 0) begin
      $error("unexpected result 0x%0h with nothing outstanding", got);
      fails++;
    end else begin
      want = awaited_q.pop_front();
      check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
      check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
      check_field("last", 32'(want.last), 32'(got.last));
      check_field("read_done", 32'(want.read_done), 32'(got.read_done));
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("read_value", want.read_value, got.read_value);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_ticks = TIMEOUT_RESET;
      drop_read();
      awaited_q.delete();
      fails = 0;
      seen  = 0;
      fail_cnt_o <= 0;
      due_cnt_o  <= 0;
      seen_cnt_o <= 0;
    end else begin
      // outputs are registered, so a result never belongs to a request of this edge
      if (pop_i && !empty_i) begin
        check_result(rsp_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        tmo_ticks = cfg_data_i;
      end
      if (push_i && !full_i) begin
        predict_link_results(req_i);
      end
      fail_cnt_o <= fails;
      due_cnt_o  <= awaited_q.size();
      seen_cnt_o <= seen;
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import rdm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 50;
  localparam int SETTLE      = 24;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  req_t        req       = '0;
  logic        empty;
  logic        pop       = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;
  logic        calm      = 1'b0;
  logic [15:0] tmo_now   = TIMEOUT_RESET;
  int          fail_cnt;
  int          due_cnt;
  int          seen_cnt;
  int          cycles    = 0;
  int          sent      = 0;
  int          sent_all  = 0;
  int          quiet     = 0;

  register_datagram_uart_master_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .req_i       (req),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  rdm_link_monitor mon (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_i      (full),
    .req_i       (req),
    .empty_i     (empty),
    .pop_i       (pop),
    .rsp_i       (rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .due_cnt_o   (due_cnt),
    .seen_cnt_o  (seen_cnt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    pop <= calm || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", due_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // reply CRC for building well-formed replies
  function automatic logic [7:0] link_crc(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    int         i;
    c = crc;
    d = data;
    for (i = 0; i < 8; i++) begin
      c = (c[7] ^ d[0]) ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      d = d >> 1;
    end
    return c;
  endfunction

  function automatic req_t any_req(input logic [1:0] cmd);
    req_t r;
    r.cmd         = cmd;
    r.node_addr   = 8'($urandom);
    r.reg_addr    = 7'($urandom);
    r.write_value = $urandom;
    r.rx_byte     = 8'($urandom);
    return r;
  endfunction

  task automatic send_item(input req_t r, input bit counted);
    while (!calm && $urandom_range(0, 99) < 8) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req  <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_all++;
    if (counted) begin
      sent++;
    end
  endtask

  task automatic send_fields(input logic [1:0] cmd, input logic [7:0] node,
                             input logic [6:0] rg, input logic [31:0] val,
                             input logic [7:0] rx);
    req_t r;
    r.cmd         = cmd;
    r.node_addr   = node;
    r.reg_addr    = rg;
    r.write_value = val;
    r.rx_byte     = rx;
    send_item(r, 1'b0);
  endtask

  task automatic send_rx(input logic [7:0] b);
    req_t r;
    r = any_req(CMD_RX);
    r.rx_byte = b;
    send_item(r, 1'b1);
    quiet = 0;
  endtask

  task automatic send_tick();
    send_item(any_req(CMD_TICK), 1'b1);
    quiet++;
  endtask

  // ticks between bytes, kept below the timeout so the read survives
  task automatic maybe_tick();
    if ($urandom_range(0, 99) < 12 && quiet + 1 < int'(tmo_now)) begin
      send_tick();
    end
  endtask

  task automatic run_write();
    req_t r;
    r = any_req(CMD_WRITE);
    case ($urandom_range(0, 5))
      0: begin
        r.node_addr   = '0;
        r.reg_addr    = '0;
        r.write_value = '0;
      end
      1: begin
        r.node_addr   = '1;
        r.reg_addr    = '1;
        r.write_value = '1;
      end
      default: ;
    endcase
    send_item(r, 1'b1);
  endtask

  // read request, then the first upto bytes of echo plus reply (12 is the full exchange)
  task automatic run_read(input int upto);
    req_t       r;
    logic [6:0] want;
    logic [7:0] reply [8];
    bit         faulty;
    int         i;
    r = any_req(CMD_READ);
    want = r.reg_addr;
    send_item(r, 1'b1);
    quiet = 0;
    faulty = ($urandom_range(0, 99) < 40);
    reply[0] = SYNC_BYTE;
    reply[1] = 8'($urandom);
    reply[2] = {1'b0, want};
    for (i = 3; i < 7; i++) begin
      reply[i] = 8'($urandom);
    end
    if (faulty && $urandom_range(0, 1)) begin
      reply[0] = SYNC_BYTE ^ 8'($urandom_range(1, 255));
    end
    if (faulty && $urandom_range(0, 1)) begin
      reply[2] = $urandom_range(0, 1) ? {1'b1, want} : {1'b0, want ^ 7'($urandom_range(1, 127))};
    end
    reply[7] = '0;
    for (i = 0; i < 7; i++) begin
      reply[7] = link_crc(reply[7], reply[i]);
    end
    if (faulty && $urandom_range(0, 1)) begin
      reply[7] = reply[7] ^ 8'($urandom_range(1, 255));
    end
    for (i = 0; i < upto; i++) begin
      maybe_tick();
      send_rx((i < ECHO_BYTES) ? 8'($urandom) : reply[i - ECHO_BYTES]);
    end
  endtask

  task automatic run_timeout();
    int n;
    int i;
    run_read($urandom_range(0, 11));
    // with a huge timeout just tick a little; the next request cancels the read
    n = (tmo_now > 40) ? 10 : ((tmo_now == 0) ? 1 : int'(tmo_now));
    for (i = 0; i < n; i++) begin
      send_tick();
    end
  endtask

  task automatic run_noise();
    int n;
    int i;
    n = $urandom_range(1, 3);
    for (i = 0; i < n; i++) begin
      send_item(any_req(2'($urandom_range(0, 3))), 1'b0);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (due_cnt != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tmo_now = v;
  endtask

  initial begin
    int          ph;
    int          start;
    int          k;
    logic [15:0] mid;
    mid = 16'($urandom_range(2, 12));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, idle bytes/ticks, cancel, timeout, multi-fault reply
    send_fields(CMD_WRITE, 8'h00, 7'h00, 32'h0000_0000, 8'h00);
    send_fields(CMD_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    send_fields(CMD_RX, 8'hFF, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    send_fields(CMD_TICK, 8'h00, 7'h00, 32'h0000_0000, 8'h00);
    send_fields(CMD_READ, 8'hFF, 7'h7F, 32'h0000_0000, 8'h00);
    send_fields(CMD_WRITE, 8'h5A, 7'h33, 32'h1234_5678, 8'h00);
    send_fields(CMD_READ, 8'h01, 7'h11, 32'h0000_0000, 8'h00);
    repeat (5) send_fields(CMD_TICK, 8'h00, 7'h00, 32'h0, 8'h00);
    send_fields(CMD_READ, 8'hA3, 7'h2A, 32'h0, 8'h00);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'hFF);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'h00);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'hFF);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'h00);
    // bad sync, register with bit 7 set and a wrong CRC all at once
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'h00);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'hA3);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'hAA);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'hDE);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'hAD);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'hBE);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'hEF);
    send_fields(CMD_RX, 8'h00, 7'h00, 32'h0, 8'h00);

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_timeout(16'd0);
        1: set_timeout(16'd1);
        2: set_timeout(16'hFFFF);
        3: set_timeout(mid);
        default: set_timeout(TIMEOUT_RESET);
      endcase
      calm <= (ph == 2);
      start = sent;
      while (sent - start < PHASE_ITEMS) begin
        k = $urandom_range(0, 99);
        if (k < 15) begin
          run_write();
        end else if (k < 60) begin
          run_read(12);
        end else if (k < 72) begin
          run_timeout();
        end else if (k < 85) begin
          run_read($urandom_range(0, 11));
          if ($urandom_range(0, 1)) begin
            run_write();
          end else begin
            run_read(12);
          end
        end else begin
          run_noise();
        end
      end
    end

    drain();
    $display("ran %0d requests (%0d in random sequences), %0d results checked",
             sent_all, sent, seen_cnt);
    $display("timeouts 0, 1, %0d, 65535 and 5; good replies, faults, cancels, expiries", mid);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/rdm_pkg.sv
sv/rdm_front.sv
sv/rdm_jobq.sv
sv/rdm_back.sv
sv/register_datagram_uart_master.sv
tb/sv/rdm_link_monitor.sv
tb/sv/tb.sv
